### rtl/pvts_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pvts_pkg
// Shared types and constants for the periodic volume trilinear sampler.
// ----------------------------------------------------------------------------
package pvts_pkg;

   localparam int DATA_W  = 32;
   localparam int COORD_W = 19;
   localparam int IDX_W   = 6;
   localparam int SIZE_W  = 7;
   localparam int FRAC_W  = 16;
   localparam int ACT_W   = 2;
   localparam int CSR_W   = 2;

   // action codes
   localparam logic [ACT_W-1:0] ACT_WRITE  = 2'd0;
   localparam logic [ACT_W-1:0] ACT_SAMPLE = 2'd1;
   localparam logic [ACT_W-1:0] ACT_CLEAR  = 2'd2;

   // register indexes
   localparam logic [CSR_W-1:0] CSR_SIZE_X = 2'd0;
   localparam logic [CSR_W-1:0] CSR_SIZE_Y = 2'd1;
   localparam logic [CSR_W-1:0] CSR_SIZE_Z = 2'd2;

   localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd64;
   localparam logic [19:0] FIVE_Q16 = 20'd327680;
   localparam logic [16:0] ONE_Q16  = 17'd65536;

   localparam logic signed [DATA_W-1:0] DATA_MAX = 32'sh7fffffff;
   localparam logic signed [DATA_W-1:0] DATA_MIN = 32'sh80000000;

   // control of the shared blend unit
   typedef struct packed {
      logic               en;
      logic               load;
      logic [FRAC_W-1:0]  frac;
   } lerp_ctl_type;

endpackage

### rtl/pvts_lerp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pvts_lerp
// Linear blend: a load step registers (1-f)*a, a later step without load adds
// f*b, rounds half up from signed Q34.16 to an integer and saturates.
// ----------------------------------------------------------------------------
module pvts_lerp (
   input  logic                               clock,
   input  pvts_pkg::lerp_ctl_type             ctl,
   input  logic signed [pvts_pkg::DATA_W-1:0] operand,
   output logic signed [pvts_pkg::DATA_W-1:0] result
);
   import pvts_pkg::*;

   logic [16:0]        weight;
   logic signed [49:0] prod;
   logic signed [49:0] acc_ff;
   logic signed [50:0] sum;
   logic signed [34:0] quo;

   assign weight = ctl.load ? (ONE_Q16 - {1'b0, ctl.frac}) : {1'b0, ctl.frac};
   assign prod   = $signed({1'b0, weight}) * operand;
   assign sum    = 51'(acc_ff) + 51'(prod) + 51'sd32768;
   assign quo    = sum[50:16];

   always_comb begin
      if (quo[34:31] == 4'b0000 || quo[34:31] == 4'b1111) begin
         result = quo[31:0];
      end else if (quo[34]) begin
         result = DATA_MIN;
      end else begin
         result = DATA_MAX;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.en && ctl.load) begin
         acc_ff <= prod;
      end
   end

endmodule

### rtl/periodic_volume_trilinear_sampler_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// periodic_volume_trilinear_sampler_core
// Periodic 3D density grid with trilinear sampling and running min/max.
// ----------------------------------------------------------------------------
// A voxel write or a min/max clear completes in the cycle that accepts it. A
// sample is accepted, then its coordinates are scaled, then the corner indices
// are wrapped into the grid (one compare and subtract per axis per cycle, at
// least one subtract is always needed, then a check that all axes are in
// range), then the eight corners are read from the single-port volume memory
// while the shared blend multiplier forms the x blends, then it forms the z
// and y blends, and the result is posted once the output register is free.
// A finished result waits there while the next transaction is taken.
module periodic_volume_trilinear_sampler_core #(
   parameter int GRID_MAX = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [pvts_pkg::ACT_W-1:0]          req_action,
   input  logic [pvts_pkg::IDX_W-1:0]          req_voxel_x,
   input  logic [pvts_pkg::IDX_W-1:0]          req_voxel_y,
   input  logic [pvts_pkg::IDX_W-1:0]          req_voxel_z,
   input  logic signed [pvts_pkg::DATA_W-1:0]  req_voxel_value,
   input  logic signed [pvts_pkg::COORD_W-1:0] req_coord_x,
   input  logic signed [pvts_pkg::COORD_W-1:0] req_coord_y,
   input  logic signed [pvts_pkg::COORD_W-1:0] req_coord_z,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [pvts_pkg::DATA_W-1:0]  rsp_sample_value,
   output logic signed [pvts_pkg::DATA_W-1:0]  rsp_min_value,
   output logic signed [pvts_pkg::DATA_W-1:0]  rsp_max_value,
   input  logic                                csr_we,
   input  logic [pvts_pkg::CSR_W-1:0]          csr_index,
   input  logic [pvts_pkg::SIZE_W-1:0]         csr_wdata
);
   import pvts_pkg::*;

   localparam int LW    = $clog2(GRID_MAX);
   localparam int CW    = $clog2(GRID_MAX + 1);
   localparam int IW    = $clog2(9 * GRID_MAX);
   localparam int EW    = (LW > IDX_W) ? LW : IDX_W;
   localparam int KW    = (CW > SIZE_W) ? CW : SIZE_W;
   localparam int AW    = 3 * LW;
   localparam int DEPTH = 1 << AW;
   localparam int PW    = 20 + CW;

   typedef enum logic [2:0] {
      ST_IDLE, ST_SCALE, ST_WRAP, ST_FETCH, ST_BLEND, ST_FINISH
   } state_type;

   state_type state_ff;

   logic [SIZE_W-1:0]         size_ff [3];
   logic [CW-1:0]             sz      [3];
   logic signed [COORD_W-1:0] coord_ff[3];
   logic [IW-1:0]             i_ff    [3];
   logic [FRAC_W-1:0]         frac_ff [3];
   logic [LW-1:0]             lo      [3];
   logic [LW-1:0]             hi      [3];
   logic [2:0]                below;
   logic [3:0]                cnt_ff;
   logic [2:0]                k;

   logic signed [DATA_W-1:0]  mem [DEPTH];
   logic signed [DATA_W-1:0]  rdata_ff;
   logic                      mem_we;
   logic [AW-1:0]             mem_addr;
   logic [AW-1:0]             waddr;
   logic [AW-1:0]             raddr;
   logic [EW-1:0]             wx, wy, wz;
   logic                      in_range;
   logic                      req_take;

   logic signed [DATA_W-1:0]  p_ff [4];
   logic signed [DATA_W-1:0]  p5_ff, p6_ff, d_ff;
   logic signed [DATA_W-1:0]  min_ff, max_ff;
   logic signed [DATA_W-1:0]  new_min, new_max;
   logic                      rsp_valid_ff;
   logic signed [DATA_W-1:0]  sample_ff, min_out_ff, max_out_ff;

   lerp_ctl_type              lctl;
   logic signed [DATA_W-1:0]  lop;
   logic signed [DATA_W-1:0]  lres;

   // size clamp: zero acts as one, anything above the grid acts as the grid
   always_comb begin
      for (int a = 0; a < 3; a++) begin
         if (size_ff[a] == '0) begin
            sz[a] = CW'(1);
         end else if (KW'(size_ff[a]) > KW'(GRID_MAX)) begin
            sz[a] = CW'(GRID_MAX);
         end else begin
            sz[a] = CW'(size_ff[a]);
         end
      end
   end

   always_comb begin
      for (int a = 0; a < 3; a++) begin
         below[a] = (i_ff[a] < IW'(sz[a]));
         lo[a]    = i_ff[a][LW-1:0];
         if ((CW'(lo[a]) + CW'(1)) == sz[a]) begin
            hi[a] = '0;
         end else begin
            hi[a] = lo[a] + LW'(1);
         end
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign req_take  = req_valid && req_ready;

   assign wx       = EW'(req_voxel_x);
   assign wy       = EW'(req_voxel_y);
   assign wz       = EW'(req_voxel_z);
   assign in_range = ({1'b0, wx} < (EW+1)'(GRID_MAX)) && ({1'b0, wy} < (EW+1)'(GRID_MAX))
                  && ({1'b0, wz} < (EW+1)'(GRID_MAX));
   assign mem_we   = req_take && (req_action == ACT_WRITE) && in_range;
   assign waddr    = {wx[LW-1:0], wy[LW-1:0], wz[LW-1:0]};

   // corner select: bit 0 picks x, bit 1 picks z, bit 2 picks y
   assign raddr    = {cnt_ff[0] ? hi[0] : lo[0],
                      cnt_ff[2] ? hi[1] : lo[1],
                      cnt_ff[1] ? hi[2] : lo[2]};
   assign mem_addr = mem_we ? waddr : raddr;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_addr] <= req_voxel_value;
      end else begin
         rdata_ff <= mem[mem_addr];
      end
   end

   assign k = 3'(cnt_ff - 4'd1);

   always_comb begin
      lctl = '0;
      lop  = rdata_ff;
      if (state_ff == ST_FETCH && cnt_ff != 4'd0) begin
         lctl.en   = 1'b1;
         lctl.load = !k[0];
         lctl.frac = frac_ff[0];
      end else if (state_ff == ST_BLEND) begin
         lctl.en   = 1'b1;
         lctl.load = !cnt_ff[0];
         lctl.frac = cnt_ff[2] ? frac_ff[1] : frac_ff[2];
         case (cnt_ff[2:0])
            3'd0:    lop = p_ff[0];
            3'd1:    lop = p_ff[1];
            3'd2:    lop = p_ff[2];
            3'd3:    lop = p_ff[3];
            3'd4:    lop = p5_ff;
            default: lop = p6_ff;
         endcase
      end
   end

   pvts_lerp u_lerp (
      .clock   (clock),
      .ctl     (lctl),
      .operand (lop),
      .result  (lres)
   );

   assign new_min = (d_ff < min_ff) ? d_ff : min_ff;
   assign new_max = (d_ff > max_ff) ? d_ff : max_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         min_ff       <= DATA_MAX;
         max_ff       <= DATA_MIN;
         for (int a = 0; a < 3; a++) begin
            size_ff[a] <= SIZE_RESET;
         end
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               CSR_SIZE_X: size_ff[0] <= csr_wdata;
               CSR_SIZE_Y: size_ff[1] <= csr_wdata;
               CSR_SIZE_Z: size_ff[2] <= csr_wdata;
               default: ;
            endcase
         end
         // the finish state reloads the output register itself
         if (rsp_valid_ff && rsp_ready && state_ff != ST_FINISH) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_take) begin
                  if (req_action == ACT_SAMPLE) begin
                     coord_ff[0] <= req_coord_x;
                     coord_ff[1] <= req_coord_y;
                     coord_ff[2] <= req_coord_z;
                     state_ff    <= ST_SCALE;
                  end else if (req_action == ACT_CLEAR) begin
                     min_ff <= DATA_MAX;
                     max_ff <= DATA_MIN;
                  end
               end
            end
            ST_SCALE: begin
               for (int a = 0; a < 3; a++) begin
                  automatic logic [19:0]   u = 20'({coord_ff[a][COORD_W-1], coord_ff[a]})
                                                + FIVE_Q16;
                  automatic logic [PW-1:0] s = PW'(u) * PW'(sz[a]);
                  i_ff[a]    <= s[FRAC_W +: IW];
                  frac_ff[a] <= s[FRAC_W-1:0];
               end
               state_ff <= ST_WRAP;
            end
            ST_WRAP: begin
               if (&below) begin
                  cnt_ff   <= '0;
                  state_ff <= ST_FETCH;
               end else begin
                  for (int a = 0; a < 3; a++) begin
                     if (!below[a]) begin
                        i_ff[a] <= i_ff[a] - IW'(sz[a]);
                     end
                  end
               end
            end
            ST_FETCH: begin
               if (cnt_ff != 4'd0 && k[0]) begin
                  p_ff[k[2:1]] <= lres;
               end
               if (cnt_ff == 4'd8) begin
                  cnt_ff   <= '0;
                  state_ff <= ST_BLEND;
               end else begin
                  cnt_ff <= cnt_ff + 4'd1;
               end
            end
            ST_BLEND: begin
               case (cnt_ff[2:0])
                  3'd1:    p5_ff <= lres;
                  3'd3:    p6_ff <= lres;
                  3'd5:    d_ff  <= lres;
                  default: ;
               endcase
               if (cnt_ff == 4'd5) begin
                  state_ff <= ST_FINISH;
               end else begin
                  cnt_ff <= cnt_ff + 4'd1;
               end
            end
            ST_FINISH: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  min_ff       <= new_min;
                  max_ff       <= new_max;
                  sample_ff    <= d_ff;
                  min_out_ff   <= new_min;
                  max_out_ff   <= new_max;
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_sample_value = sample_ff;
   assign rsp_min_value    = min_out_ff;
   assign rsp_max_value    = max_out_ff;

endmodule

### dv/pvts_sample_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pvts_sample_checker
// Watches the request, result and register ports of the trilinear sampler,
// keeps its own copy of the density grid, the running min/max and the grid
// sizes, works out each sample and compares every result field in order.
// ----------------------------------------------------------------------------
module pvts_sample_checker
   import pvts_pkg::*;
#(
   parameter int GRID_MAX = 64
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic                       req_ready,
   input  logic [ACT_W-1:0]           req_action,
   input  logic [IDX_W-1:0]           req_voxel_x,
   input  logic [IDX_W-1:0]           req_voxel_y,
   input  logic [IDX_W-1:0]           req_voxel_z,
   input  logic signed [DATA_W-1:0]   req_voxel_value,
   input  logic signed [COORD_W-1:0]  req_coord_x,
   input  logic signed [COORD_W-1:0]  req_coord_y,
   input  logic signed [COORD_W-1:0]  req_coord_z,
   input  logic                       rsp_valid,
   input  logic                       rsp_ready,
   input  logic signed [DATA_W-1:0]   rsp_sample_value,
   input  logic signed [DATA_W-1:0]   rsp_min_value,
   input  logic signed [DATA_W-1:0]   rsp_max_value,
   input  logic                       csr_we,
   input  logic [CSR_W-1:0]           csr_index,
   input  logic [SIZE_W-1:0]          csr_wdata,
   output int                         fail_count,
   output int                         samples_pending,
   output int                         samples_checked
);

   typedef struct {
      logic signed [DATA_W-1:0] sample;
      logic signed [DATA_W-1:0] lowest;
      logic signed [DATA_W-1:0] highest;
   } sample_result_type;

   logic signed [DATA_W-1:0] grid_model [int];
   logic signed [DATA_W-1:0] run_min;
   logic signed [DATA_W-1:0] run_max;
   logic [SIZE_W-1:0]        grid_size [3];
   sample_result_type        expected_samples [$];

   function automatic int eff_size(logic [SIZE_W-1:0] s);
      if (s < 1) return 1;
      if (s > GRID_MAX) return GRID_MAX;
      return s;
   endfunction

   // lower corner, upper corner and upper weight along one axis
   function automatic void split_axis(logic signed [COORD_W-1:0] c, int n,
                                      output int lo, output int hi,
                                      output longint w);
      logic [31:0] s;
      s  = (32'(int'(c)) + 32'(FIVE_Q16)) * 32'(n);
      lo = int'(s >> 16) % n;
      hi = (int'(s >> 16) + 1) % n;
      w  = longint'(s[15:0]);
   endfunction

   function automatic logic signed [DATA_W-1:0] blend(logic signed [DATA_W-1:0] a,
                                                      logic signed [DATA_W-1:0] b,
                                                      longint w);
      longint acc;
      acc = (65536 - w) * longint'(a) + w * longint'(b) + 32768;
      acc = acc >>> 16;
      if (acc > longint'(DATA_MAX)) return DATA_MAX;
      if (acc < longint'(DATA_MIN)) return DATA_MIN;
      return acc[DATA_W-1:0];
   endfunction

   function automatic logic signed [DATA_W-1:0] voxel(int x, int y, int z);
      int a;
      a = (x * GRID_MAX + y) * GRID_MAX + z;
      return grid_model.exists(a) ? grid_model[a] : '0;
   endfunction

   function automatic logic signed [DATA_W-1:0] interp_sample();
      int x0, x1, y0, y1, z0, z1;
      longint fx, fy, fz;
      logic signed [DATA_W-1:0] p1, p2, p3, p4;
      split_axis(req_coord_x, eff_size(grid_size[0]), x0, x1, fx);
      split_axis(req_coord_y, eff_size(grid_size[1]), y0, y1, fy);
      split_axis(req_coord_z, eff_size(grid_size[2]), z0, z1, fz);
      p1 = blend(voxel(x0, y0, z0), voxel(x1, y0, z0), fx);
      p2 = blend(voxel(x0, y1, z0), voxel(x1, y1, z0), fx);
      p3 = blend(voxel(x0, y0, z1), voxel(x1, y0, z1), fx);
      p4 = blend(voxel(x0, y1, z1), voxel(x1, y1, z1), fx);
      return blend(blend(p1, p3, fz), blend(p2, p4, fz), fy);
   endfunction

   always @(posedge clock) begin
      sample_result_type r;
      sample_result_type e;
      if (reset) begin
         run_min      <= DATA_MAX;
         run_max      <= DATA_MIN;
         grid_size[0] <= SIZE_RESET;
         grid_size[1] <= SIZE_RESET;
         grid_size[2] <= SIZE_RESET;
      end else begin
         if (rsp_valid && rsp_ready) begin
            samples_checked++;
            if (expected_samples.size() == 0) begin
               $error("unexpected result transaction, sample_value %0d", rsp_sample_value);
               fail_count++;
            end else begin
               e = expected_samples.pop_front();
               if (rsp_sample_value !== e.sample) begin
                  $error("sample_value expected %0d actual %0d", e.sample, rsp_sample_value);
                  fail_count++;
               end
               if (rsp_min_value !== e.lowest) begin
                  $error("min_value expected %0d actual %0d", e.lowest, rsp_min_value);
                  fail_count++;
               end
               if (rsp_max_value !== e.highest) begin
                  $error("max_value expected %0d actual %0d", e.highest, rsp_max_value);
                  fail_count++;
               end
            end
         end
         if (req_valid && req_ready) begin
            case (req_action)
               ACT_WRITE:
                  grid_model[(int'(req_voxel_x) * GRID_MAX + int'(req_voxel_y)) * GRID_MAX
                             + int'(req_voxel_z)] = req_voxel_value;
               ACT_CLEAR: begin
                  run_min <= DATA_MAX;
                  run_max <= DATA_MIN;
               end
               ACT_SAMPLE: begin
                  r.sample  = interp_sample();
                  r.lowest  = (r.sample < run_min) ? r.sample : run_min;
                  r.highest = (r.sample > run_max) ? r.sample : run_max;
                  run_min  <= r.lowest;
                  run_max  <= r.highest;
                  expected_samples.push_back(r);
               end
               default: ;
            endcase
         end
         if (csr_we) begin
            case (csr_index)
               CSR_SIZE_X: grid_size[0] <= csr_wdata;
               CSR_SIZE_Y: grid_size[1] <= csr_wdata;
               CSR_SIZE_Z: grid_size[2] <= csr_wdata;
               default: ;
            endcase
         end
         samples_pending = expected_samples.size();
      end
   end

   initial begin
      fail_count      = 0;
      samples_pending = 0;
      samples_checked = 0;
   end

endmodule

### dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives the trilinear sampler through grid size settings; each fills the grid
// region in use, then gets random writes, samples and clears (directed ones
// too for the first) under varying idle patterns and one long output stall.
// ----------------------------------------------------------------------------
module tb_top;
   import pvts_pkg::*;

   localparam int GRID_MAX = 64;
   localparam int N_SET    = 7;
   localparam int DRAIN    = 40;
   localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;
   localparam logic [CSR_W-1:0] CSR_UNUSED = 2'd3;

   logic                      clock;
   logic                      reset;
   logic                      req_valid;
   logic                      req_ready;
   logic [ACT_W-1:0]          req_action;
   logic [IDX_W-1:0]          req_voxel_x;
   logic [IDX_W-1:0]          req_voxel_y;
   logic [IDX_W-1:0]          req_voxel_z;
   logic signed [DATA_W-1:0]  req_voxel_value;
   logic signed [COORD_W-1:0] req_coord_x;
   logic signed [COORD_W-1:0] req_coord_y;
   logic signed [COORD_W-1:0] req_coord_z;
   logic                      rsp_valid;
   logic                      rsp_ready;
   logic signed [DATA_W-1:0]  rsp_sample_value;
   logic signed [DATA_W-1:0]  rsp_min_value;
   logic signed [DATA_W-1:0]  rsp_max_value;
   logic                      csr_we;
   logic [CSR_W-1:0]          csr_index;
   logic [SIZE_W-1:0]         csr_wdata;

   int  fail_count;
   int  samples_pending;
   int  samples_checked;
   int  tx_idle_pct;
   int  rx_idle_pct;
   bit  hold_output;
   int  sent_count;
   int  ext [3];

   // size settings, extremes and out-of-range codes among them
   int set_x [N_SET] = '{2, 64, 0, 1, 127, 3, 1};
   int set_y [N_SET] = '{3, 1, 64, 1, 1, 4, 1};
   int set_z [N_SET] = '{2, 1, 1, 64, 0, 3, 1};

   periodic_volume_trilinear_sampler_core #(.GRID_MAX(GRID_MAX)) i_dut (.*);

   pvts_sample_checker #(.GRID_MAX(GRID_MAX)) i_checker (.*);

   always #4 clock = ~clock;

   initial begin
      #20_000_000;
      $display("periodic_volume_trilinear_sampler_core verification failed");
      $finish;
   end

   // output side: random stalls, plus one long hold-off on request
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_output) begin
            hold_output = 1'b0;
            rsp_ready <= 1'b0;
            repeat (300) @(negedge clock);
         end else begin
            rsp_ready <= ($urandom_range(99) >= rx_idle_pct);
         end
      end
   end

   function automatic int clamp_size(int s);
      if (s < 1) return 1;
      if (s > GRID_MAX) return GRID_MAX;
      return s;
   endfunction

   function automatic logic signed [COORD_W-1:0] pick_coord();
      case ($urandom_range(9))
         0: return {1'b1, {(COORD_W-1){1'b0}}};
         1: return {1'b0, {(COORD_W-1){1'b1}}};
         2: return '0;
         default: return COORD_W'($urandom);
      endcase
   endfunction

   function automatic logic signed [DATA_W-1:0] pick_density();
      case ($urandom_range(11))
         0: return DATA_MAX;
         1: return DATA_MIN;
         default: return $urandom;
      endcase
   endfunction

   // called at a falling edge, returns at the falling edge after acceptance
   task automatic send(logic [ACT_W-1:0] act, int vx, int vy, int vz,
                       logic signed [DATA_W-1:0] val);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_action      <= act;
      req_voxel_x     <= IDX_W'(vx);
      req_voxel_y     <= IDX_W'(vy);
      req_voxel_z     <= IDX_W'(vz);
      req_voxel_value <= val;
      req_coord_x     <= pick_coord();
      req_coord_y     <= pick_coord();
      req_coord_z     <= pick_coord();
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sent_count++;
      @(negedge clock);
   endtask

   task automatic sample_point();
      send(ACT_SAMPLE, $urandom_range(63), $urandom_range(63), $urandom_range(63), $urandom);
   endtask

   task automatic write_in_region(logic signed [DATA_W-1:0] val);
      send(ACT_WRITE, $urandom_range(ext[0] - 1), $urandom_range(ext[1] - 1),
           $urandom_range(ext[2] - 1), val);
   endtask

   // registers change only with nothing in flight
   task automatic apply_sizes(int sx, int sy, int sz);
      req_valid <= 1'b0;
      @(negedge clock);
      while (samples_pending != 0) @(negedge clock);
      repeat (DRAIN) @(negedge clock);
      csr_we <= 1'b1; csr_index <= CSR_SIZE_X; csr_wdata <= SIZE_W'(sx);
      @(negedge clock);
      csr_index <= CSR_SIZE_Y; csr_wdata <= SIZE_W'(sy);
      @(negedge clock);
      csr_index <= CSR_SIZE_Z; csr_wdata <= SIZE_W'(sz);
      @(negedge clock);
      csr_index <= CSR_UNUSED; csr_wdata <= SIZE_W'($urandom);
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
      ext[0] = clamp_size(sx);
      ext[1] = clamp_size(sy);
      ext[2] = clamp_size(sz);
   endtask

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_action = ACT_WRITE;
      req_voxel_x = '0;
      req_voxel_y = '0;
      req_voxel_z = '0;
      req_voxel_value = '0;
      req_coord_x = '0;
      req_coord_y = '0;
      req_coord_z = '0;
      csr_we = 1'b0;
      csr_index = CSR_SIZE_X;
      csr_wdata = '0;
      hold_output = 1'b0;
      sent_count = 0;
      tx_idle_pct = 22;
      rx_idle_pct = 50;
      repeat (6) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      for (int s = 0; s < N_SET; s++) begin
         if (s == 3) begin
            tx_idle_pct = 50;
            rx_idle_pct = 22;
         end else if (s == 5) begin
            tx_idle_pct = 0;
            rx_idle_pct = 0;
         end
         apply_sizes(set_x[s], set_y[s], set_z[s]);

         // every voxel a sample can reach gets written first
         for (int x = 0; x < ext[0]; x++)
            for (int y = 0; y < ext[1]; y++)
               for (int z = 0; z < ext[2]; z++)
                  send(ACT_WRITE, x, y, z, pick_density());

         if (s == 0) begin
            send(ACT_WRITE, 0, 0, 0, DATA_MAX);
            send(ACT_WRITE, 1, 0, 0, DATA_MIN);
            send(ACT_WRITE, 1, 2, 1, DATA_MAX);
            send(ACT_WRITE, 63, 63, 63, -1);
            send(ACT_UNUSED, 63, 63, 63, DATA_MIN);
            for (int k = 0; k < 6; k++) sample_point();
            send(ACT_CLEAR, 0, 0, 0, 0);
            sample_point();
            send(ACT_WRITE, 0, 1, 1, DATA_MIN);
            send(ACT_WRITE, 1, 1, 0, '0);
            for (int k = 0; k < 4; k++) sample_point();
            send(ACT_CLEAR, 63, 63, 63, -1);
            send(ACT_CLEAR, 0, 0, 0, 0);
            sample_point();
         end

         for (int k = 0; k < 25; k++) begin
            if (s == 5 && k == 10) hold_output = 1'b1;
            case ($urandom_range(99)) inside
               [0:44]:  sample_point();
               [45:79]: write_in_region(pick_density());
               [80:89]: send(ACT_WRITE, $urandom_range(63), $urandom_range(63),
                             $urandom_range(63), pick_density());
               [90:95]: send(ACT_CLEAR, $urandom_range(63), $urandom_range(63),
                             $urandom_range(63), $urandom);
               default: send(ACT_UNUSED, $urandom_range(63), $urandom_range(63),
                             $urandom_range(63), $urandom);
            endcase
         end
      end

      req_valid <= 1'b0;
      @(negedge clock);
      while (samples_pending != 0) @(negedge clock);
      repeat (DRAIN) @(negedge clock);
      $display("sent %0d transactions over %0d grid size settings", sent_count, N_SET);
      $display("checked %0d sample results against the predicted blend", samples_checked);
      if (fail_count == 0)
         $display("periodic_volume_trilinear_sampler_core verification clean");
      else
         $display("periodic_volume_trilinear_sampler_core verification failed");
      $finish;
   end

endmodule

### files.f
rtl/pvts_pkg.sv
rtl/pvts_lerp.sv
rtl/periodic_volume_trilinear_sampler_core.sv
dv/pvts_sample_checker.sv
dv/tb_top.sv
